>>> src/assert_macros.svh
// Assertion macros used by the checker file of the gap scorer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AGBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AGBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/agbs_pkg.sv
// Shared types, constants and the log table of the alignment block gap scorer.
`default_nettype none

package agbs_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int FRAC_BITS      = 16;
    localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
    localparam int GAP_W          = 31;
    localparam int EXP_W          = 5;
    localparam int LG_W           = EXP_W + FRAC_BITS;
    localparam int LN2_W          = 30;
    localparam int PEN_W          = LG_W + 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic [LN2_W-1:0]  LN2_Q30   = 30'd744261118;
    localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

    // How a block is handled by the back end.
    typedef enum logic [2:0] {
        CLS_FIRST,
        CLS_NONE,
        CLS_QUERY,
        CLS_TARGET,
        CLS_BOTH
    } cls_t;

    // One classified item. val holds the saturated base score for a first
    // block, the positive gap for a gap class and zero for CLS_NONE.
    typedef struct packed {
        cls_t        cls;
        logic        last;
        logic [31:0] val;
    } entry_t;

    typedef logic [FRAC_BITS-1:0] log_table_t [TABLE_SIZE];

    // Entry m is log2(1 + m/TABLE_SIZE), one result bit per squaring step.
    function automatic log_table_t build_log_table();
        log_table_t           tab;
        logic [63:0]          x;
        logic [FRAC_BITS-1:0] r;
        for (int m = 0; m < TABLE_SIZE; m++)
        begin
            x = 64'(TABLE_SIZE + m) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= (64'd2 << 30))
                begin
                    r[0] = 1'b1;
                    x    = x >> 1;
                end
            end
            tab[m] = r;
        end
        return tab;
    endfunction

    localparam log_table_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

>>> src/alignment_block_gap_scorer.sv
// Top level of the alignment block gap scorer.
//
// Input channel: push/full. An item (one aligned block) is taken at a rising
// edge with push high and full low. Result channel: empty/pop. The score sits
// on alignment_score while empty is low and leaves at an edge with pop high.
// One result comes out for each item that has last_block set, in order.
// Throughput is one item per cycle while full stays low; the front end
// classifies an item in the cycle it is taken, and the back end runs a
// six-stage log, penalty and accumulate pipeline fed from a four-entry
// queue. Only the accumulate stage carries the score from one item to the
// next.
// Reset clears the previous block ends, the running score and all queues.
// When the receiver stops popping, a two-entry result queue fills, then the
// back-end pipeline freezes, then the input queue fills and full goes high.
`default_nettype none

module alignment_block_gap_scorer
    import agbs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          first_block,
    input  wire logic          last_block,
    input  wire logic [30:0]   match_count,
    input  wire logic [30:0]   repeat_match_count,
    input  wire logic [30:0]   mismatch_count,
    input  wire logic [31:0]   query_start,
    input  wire logic [31:0]   target_start,
    input  wire logic [31:0]   block_size,
    output logic               empty,
    input  wire logic          pop,
    output logic signed [31:0] alignment_score
);

    logic   accept;
    entry_t front_entry;
    entry_t q_data;
    logic   q_empty;
    logic   q_pop;

    assign accept = push && !full;

    agbs_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .first_block        (first_block),
        .last_block         (last_block),
        .match_count        (match_count),
        .repeat_match_count (repeat_match_count),
        .mismatch_count     (mismatch_count),
        .query_start        (query_start),
        .target_start       (target_start),
        .block_size         (block_size),
        .entry              (front_entry)
    );

    agbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    agbs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .alignment_score (alignment_score)
    );

endmodule

`default_nettype wire

>>> src/agbs_queue.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none

module agbs_queue
    import agbs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire entry_t wr_data,
    output logic        full,
    input  wire logic   rd_en,
    output entry_t      rd_data,
    output logic        empty
);

    entry_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(wr_en);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(rd_en);
        count_next  = count_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> src/agbs_front.sv
// Front end: measures the gaps against the previous block and classifies each item.
`default_nettype none

module agbs_front
    import agbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        first_block,
    input  wire logic        last_block,
    input  wire logic [30:0] match_count,
    input  wire logic [30:0] repeat_match_count,
    input  wire logic [30:0] mismatch_count,
    input  wire logic [31:0] query_start,
    input  wire logic [31:0] target_start,
    input  wire logic [31:0] block_size,
    output entry_t           entry
);

    logic [31:0]        prev_query_end_reg;
    logic [31:0]        prev_query_end_next;
    logic [31:0]        prev_target_end_reg;
    logic [31:0]        prev_target_end_next;
    logic [31:0]        qd;
    logic [31:0]        td;
    logic               qpos;
    logic               tpos;
    logic signed [33:0] base_sum;
    logic [31:0]        base_sat;
    logic [GAP_W-1:0]   gap_max;

    always_comb
    begin
        qd   = query_start - prev_query_end_reg;
        td   = target_start - prev_target_end_reg;
        qpos = (qd != '0) && !qd[31];
        tpos = (td != '0) && !td[31];

        base_sum = $signed({3'b000, match_count}) + $signed({3'b000, repeat_match_count})
                 - $signed({2'b00, mismatch_count, 1'b0});
        if (base_sum > 34'(SCORE_MAX))
        begin
            base_sat = SCORE_MAX;
        end
        else if (base_sum < 34'(SCORE_MIN))
        begin
            base_sat = SCORE_MIN;
        end
        else
        begin
            base_sat = base_sum[31:0];
        end

        gap_max = (qd[GAP_W-1:0] > td[GAP_W-1:0]) ? qd[GAP_W-1:0] : td[GAP_W-1:0];

        entry.last = last_block;
        // A gap on one side only counts when the other side abuts exactly;
        // an overlap on either side otherwise cancels the penalty.
        priority if (first_block)
        begin
            entry.cls = CLS_FIRST;
            entry.val = base_sat;
        end
        else if (qpos && (td == '0))
        begin
            entry.cls = CLS_QUERY;
            entry.val = {1'b0, qd[GAP_W-1:0]};
        end
        else if (tpos && (qd == '0))
        begin
            entry.cls = CLS_TARGET;
            entry.val = {1'b0, td[GAP_W-1:0]};
        end
        else if (qpos && tpos)
        begin
            entry.cls = CLS_BOTH;
            entry.val = {1'b0, gap_max};
        end
        else
        begin
            entry.cls = CLS_NONE;
            entry.val = '0;
        end

        prev_query_end_next  = accept ? (query_start + block_size) : prev_query_end_reg;
        prev_target_end_next = accept ? (target_start + block_size) : prev_target_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_query_end_reg  <= '0;
            prev_target_end_reg <= '0;
        end
        else
        begin
            prev_query_end_reg  <= prev_query_end_next;
            prev_target_end_reg <= prev_target_end_next;
        end
    end

endmodule

`default_nettype wire

>>> src/agbs_back.sv
// Back end: log pipeline, penalty, score accumulation and the result queue.
`default_nettype none

module agbs_back
    import agbs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire entry_t        q_data,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic signed [31:0] alignment_score
);

    localparam int NUM_STAGES = 6;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    typedef struct packed {
        cls_t                      cls;
        logic                      last;
        logic [31:0]               val;
        logic [EXP_W-1:0]          e;
        logic [LOG_TABLE_BITS-1:0] m;
        logic [PEN_W-1:0]          num;
    } pipe_t;

    pipe_t                stage_reg   [NUM_STAGES];
    pipe_t                stage_next  [NUM_STAGES];
    logic                 valid_reg   [NUM_STAGES];
    logic                 advance;

    logic [EXP_W-1:0]                   msb_pos;
    logic [GAP_W+LOG_TABLE_BITS-1:0]    norm;
    logic [LG_W+LN2_W-1:0]              prod;

    logic signed [31:0]   running_score_reg;
    logic signed [31:0]   running_score_next;
    logic [PEN_W-FRAC_BITS-1:0] pen_int;
    logic                 pen_frac_nz;
    logic signed [33:0]   diff;
    logic signed [33:0]   diff_adj;
    logic signed [31:0]   charged_score;

    logic signed [31:0]   out_data_reg [2];
    logic                 out_wr_reg;
    logic                 out_rd_reg;
    logic [1:0]           out_count_reg;
    logic [1:0]           out_count_next;
    logic                 out_push;
    logic                 out_pop;

    // The pipeline moves as one; it only freezes when a result must leave
    // and the result queue has no room.
    assign advance = !(valid_reg[LAST_STAGE] && stage_reg[LAST_STAGE].last
                       && (out_count_reg == 2'd2));
    assign q_pop    = advance && !q_empty;
    assign out_push = advance && valid_reg[LAST_STAGE] && stage_reg[LAST_STAGE].last;
    assign out_pop  = pop && !empty;
    assign empty    = (out_count_reg == 2'd0);
    assign alignment_score = out_data_reg[out_rd_reg];

    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < GAP_W; i++)
        begin
            if (stage_reg[0].val[i])
            begin
                msb_pos = EXP_W'(i);
            end
        end

        // Bits just below the leading one, zero-filled below bit 0.
        norm = {stage_reg[1].val[GAP_W-1:0], LOG_TABLE_BITS'(0)} >> stage_reg[1].e;
        prod = stage_reg[3].num[LG_W-1:0] * LN2_Q30;

        stage_next[0]      = '0;
        stage_next[0].cls  = q_data.cls;
        stage_next[0].last = q_data.last;
        stage_next[0].val  = q_data.val;

        stage_next[1]      = stage_reg[0];
        stage_next[1].e    = msb_pos;

        stage_next[2]      = stage_reg[1];
        stage_next[2].m    = norm[LOG_TABLE_BITS-1:0];

        stage_next[3]      = stage_reg[2];
        stage_next[3].num  = PEN_W'({stage_reg[2].e, LOG_TABLE[stage_reg[2].m]});

        stage_next[4]      = stage_reg[3];
        stage_next[4].num  = PEN_W'(prod[LG_W+LN2_W-1:LN2_W]);

        stage_next[5]      = stage_reg[4];
        unique case (stage_reg[4].cls)
            CLS_QUERY, CLS_BOTH:
                stage_next[5].num = (PEN_W'(3) << FRAC_BITS) + (stage_reg[4].num << 1);
            CLS_TARGET:
                stage_next[5].num = (PEN_W'(1) << FRAC_BITS) + stage_reg[4].num;
            default:
                stage_next[5].num = '0;
        endcase
    end

    // Truncation toward zero: a fractional penalty rounds the score down
    // only while the result stays positive.
    always_comb
    begin
        pen_int     = stage_reg[LAST_STAGE].num[PEN_W-1:FRAC_BITS];
        pen_frac_nz = |stage_reg[LAST_STAGE].num[FRAC_BITS-1:0];
        diff        = 34'(running_score_reg) - $signed(34'(pen_int));
        diff_adj    = (pen_frac_nz && (diff > 34'sd0)) ? (diff - 34'sd1) : diff;
        if (diff_adj < 34'(SCORE_MIN))
        begin
            charged_score = SCORE_MIN;
        end
        else
        begin
            charged_score = diff_adj[31:0];
        end

        unique case (stage_reg[LAST_STAGE].cls)
            CLS_FIRST:
                running_score_next = stage_reg[LAST_STAGE].val;
            CLS_QUERY, CLS_TARGET, CLS_BOTH:
                running_score_next = charged_score;
            default:
                running_score_next = running_score_reg;
        endcase

        out_count_next = out_count_reg + 2'(out_push) - 2'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            running_score_reg <= '0;
            out_wr_reg        <= 1'b0;
            out_rd_reg        <= 1'b0;
            out_count_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg[0] <= !q_empty;
                for (int k = 1; k < NUM_STAGES; k++)
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
                if (valid_reg[LAST_STAGE])
                begin
                    running_score_reg <= running_score_next;
                end
            end
            if (out_push)
            begin
                out_wr_reg <= !out_wr_reg;
            end
            if (out_pop)
            begin
                out_rd_reg <= !out_rd_reg;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (out_push)
        begin
            out_data_reg[out_wr_reg] <= running_score_next;
        end
    end

endmodule

`default_nettype wire

>>> src/agbs_checker.sv
// Port-level checker for the alignment block gap scorer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module agbs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic [31:0] alignment_score
);

    `AGBS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "result dropped while stalled")
    `AGBS_ASSERT_NEXT(a_score_held, !empty && !pop, $stable(alignment_score), "score changed")
    // The input queue can only fill while a result waits on the output side.
    `AGBS_ASSERT_SAME(a_full_needs_result, full, !empty, "full with no waiting result")
    `AGBS_ASSERT_SAME(a_full_after_stall, full, $past(!empty), "full without a prior stall")

endmodule

bind alignment_block_gap_scorer agbs_checker u_checker (.*);

`default_nettype wire
